FILE: rtl/core/brbsc_pkg.sv
// Shared types and constants for the byte ring buffer with search and checksum.
`default_nettype none
package brbsc_pkg;
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  typedef enum logic [2:0] {
    MODE_PUSH     = 3'd0,
    MODE_POP      = 3'd1,
    MODE_PEEK     = 3'd2,
    MODE_DISCARD  = 3'd3,
    MODE_SEARCH   = 3'd4,
    MODE_CHECKSUM = 3'd5
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  data_byte;
    logic [10:0] offset;
    logic [10:0] count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] result_value;
    logic [1:0]  status;
    logic [10:0] fill_level;
  } out_item_t;

  // memory port request from the controller
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

FILE: rtl/core/brbsc_mem.sv
// Byte store: one write port, one registered read port.
`default_nettype none
module brbsc_mem (
  input  wire logic               clk,
  input  wire brbsc_pkg::mem_req_t req,
  output logic [7:0]              rdata
);
  logic [7:0] mem [brbsc_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/brbsc_adler.sv
// Adler-32 accumulator: one byte per enabled cycle.
`default_nettype none
module brbsc_adler (
  input  wire logic        clk,
  input  wire logic        init,
  input  wire logic        en,
  input  wire logic [7:0]  din,
  output logic [31:0]      sum
);
  logic [15:0] a_r, b_r;
  logic [16:0] a_add, b_add;
  logic [15:0] a_nxt, b_nxt;

  always_comb begin
    a_add = {1'b0, a_r} + {9'd0, din};
    a_nxt = (a_add >= brbsc_pkg::ADLER_MOD) ? 16'(a_add - brbsc_pkg::ADLER_MOD)
                                            : a_add[15:0];
    b_add = {1'b0, b_r} + {1'b0, a_nxt};
    b_nxt = (b_add >= brbsc_pkg::ADLER_MOD) ? 16'(b_add - brbsc_pkg::ADLER_MOD)
                                            : b_add[15:0];
  end

  always_ff @(posedge clk) begin
    if (init) begin
      a_r <= 16'd1;
      b_r <= 16'd0;
    end else if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign sum = {b_r, a_r};
endmodule
`default_nettype wire

FILE: rtl/core/byte_ring_buffer_search_checksum_top.sv
// Top level: command FSM around the byte store and the Adler-32 unit.
//
// Usage: drive in_item and raise start while busy is low; the item is taken
// at that edge. One result comes back on out_item marked by out_valid for
// one cycle; the receiver cannot stall, so it must sample that cycle.
// Push, discard and unknown modes answer in the cycle after acceptance, with
// busy low throughout, so one item per cycle. Pop and peek read the store
// through its registered read port and register the byte onto out_item,
// busy while the read completes. Search reads one byte per cycle through the
// store's single read port and stays busy until its match or miss is registered.
// Checksum folds each byte read into the Adler-32 unit and stays busy until
// the sum with the last byte folded in is registered onto out_item.
// An empty checksum or out of range request answers in the next cycle.
// Synchronous active-low reset empties the FIFO; store contents are left as
// they were and are never read before being written.
`default_nettype none
module byte_ring_buffer_search_checksum_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire brbsc_pkg::in_item_t  in_item,
  output logic                      out_valid,
  output brbsc_pkg::out_item_t      out_item
);
  localparam int unsigned AW = brbsc_pkg::AW;
  localparam int unsigned CW = brbsc_pkg::CW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SRCH = 4'b0100,
    S_CSUM = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // offset being read
  logic [CW-1:0] left_r, left_nxt;   // bytes left to issue
  logic          pend_r, pend_nxt;   // a read is in flight
  logic [CW-1:0] pidx_r, pidx_nxt;   // offset of read in flight
  logic [7:0]    key_r, key_nxt;
  logic          ov_r, ov_nxt;
  brbsc_pkg::out_item_t ob_r, ob_nxt;

  brbsc_pkg::mem_req_t req;
  logic [7:0]  rdata;
  logic        a_init, a_en;
  logic [31:0] a_sum;
  logic [CW:0] span;
  logic [CW-1:0] dcnt;

  brbsc_mem u_mem (.clk(clk), .req(req), .rdata(rdata));
  brbsc_adler u_adler (.clk(clk), .init(a_init), .en(a_en), .din(rdata), .sum(a_sum));

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = ob_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = idx_r;
    key_nxt   = key_r;
    ov_nxt    = 1'b0;
    ob_nxt    = ob_r;
    req.we    = 1'b0;
    req.waddr = tail_r;
    req.wdata = in_item.data_byte;
    req.raddr = AW'(head_r + AW'(idx_r));
    a_init    = 1'b0;
    a_en      = 1'b0;
    span      = {1'b0, in_item.offset} + {1'b0, in_item.count};
    dcnt      = (in_item.count > held_r) ? held_r : in_item.count;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          ob_nxt = '0;
          ob_nxt.fill_level = held_r;
          key_nxt = in_item.data_byte;
          idx_nxt = in_item.offset;
          req.raddr = AW'(head_r + AW'(in_item.offset));
          a_init = 1'b1;
          case (in_item.mode)
            brbsc_pkg::MODE_PUSH: begin
              ov_nxt = 1'b1;
              if (held_r >= CW'(brbsc_pkg::DEPTH)) begin
                ob_nxt.status = brbsc_pkg::ST_FULL;
              end else begin
                req.we = 1'b1;
                tail_nxt = AW'(tail_r + 1'b1);
                held_nxt = held_r + 1'b1;
                ob_nxt.fill_level = held_nxt;
              end
            end
            brbsc_pkg::MODE_POP: begin
              if (held_r == '0) begin
                ov_nxt = 1'b1;
                ob_nxt.status = brbsc_pkg::ST_MISS;
              end else begin
                req.raddr = head_r;
                state_nxt = S_READ;
                held_nxt = held_r - 1'b1;
                head_nxt = (held_nxt == '0) ? '0 : AW'(head_r + 1'b1);
                if (held_nxt == '0) tail_nxt = '0;
                ob_nxt.fill_level = held_nxt;
              end
            end
            brbsc_pkg::MODE_PEEK: begin
              if (in_item.offset >= held_r) begin
                ov_nxt = 1'b1;
                ob_nxt.status = brbsc_pkg::ST_MISS;
              end else begin
                state_nxt = S_READ;
              end
            end
            brbsc_pkg::MODE_DISCARD: begin
              ov_nxt = 1'b1;
              held_nxt = held_r - dcnt;
              head_nxt = (held_nxt == '0) ? '0 : AW'(head_r + AW'(dcnt));
              if (held_nxt == '0) tail_nxt = '0;
              ob_nxt.result_value = 32'(dcnt);
              ob_nxt.fill_level = held_nxt;
            end
            brbsc_pkg::MODE_SEARCH: begin
              if (in_item.offset >= held_r) begin
                ov_nxt = 1'b1;
                ob_nxt.status = brbsc_pkg::ST_MISS;
              end else begin
                state_nxt = S_SRCH;
                pend_nxt = 1'b1;
                pidx_nxt = in_item.offset;
                idx_nxt = in_item.offset + 1'b1;
              end
            end
            brbsc_pkg::MODE_CHECKSUM: begin
              ob_nxt.result_value = 32'd1;
              if (span > {1'b0, held_r}) begin
                ov_nxt = 1'b1;
                ob_nxt.status = brbsc_pkg::ST_MISS;
              end else if (in_item.count == '0) begin
                ov_nxt = 1'b1;
              end else begin
                state_nxt = S_CSUM;
                pend_nxt = 1'b1;
                idx_nxt = in_item.offset + 1'b1;
                left_nxt = in_item.count - 1'b1;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              ob_nxt.status = brbsc_pkg::ST_MISS;
            end
          endcase
        end
      end
      S_READ: begin
        ov_nxt = 1'b1;
        ob_nxt.out_byte = rdata;
        state_nxt = S_IDLE;
      end
      S_SRCH: begin
        // rdata holds the byte at pidx_r; next read issued in parallel
        if (rdata == key_r) begin
          ov_nxt = 1'b1;
          ob_nxt.result_value = 32'(pidx_r);
          state_nxt = S_IDLE;
        end else if (pidx_r + 1'b1 >= held_r) begin
          ov_nxt = 1'b1;
          ob_nxt.status = brbsc_pkg::ST_MISS;
          state_nxt = S_IDLE;
        end else begin
          pidx_nxt = idx_r;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CSUM: begin
        if (pend_r) a_en = 1'b1;
        if (left_r != '0) begin
          pend_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
          left_nxt = left_r - 1'b1;
        end else if (!pend_r) begin
          ov_nxt = 1'b1;
          ob_nxt.result_value = a_sum;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      held_r  <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      held_r  <= held_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    pidx_r <= pidx_nxt;
    key_r  <= key_nxt;
    ob_r   <= ob_nxt;
  end
endmodule
`default_nettype wire

FILE: test/brbsc_checker.sv
// Checker: watches the command and result channels, predicts and compares.
module brbsc_checker
  import brbsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire out_item_t out_item,
  output int             fail_count,
  output int             pending_count,
  output int             result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]    fifo_mem [DEPTH];
  logic [AW-1:0] head_ptr;
  logic [AW-1:0] tail_ptr;
  int unsigned   fill;
  out_item_t     expected_q[$];

  function automatic out_item_t fifo_predict(in_item_t it);
    out_item_t r;
    int unsigned cnt;
    logic [31:0] a, b;
    r = '0;
    case (it.mode)
      MODE_PUSH: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          fifo_mem[tail_ptr] = it.data_byte;
          tail_ptr = tail_ptr + 1'b1;
          fill++;
        end
      end
      MODE_POP: begin
        if (fill == 0) begin
          r.status = ST_MISS;
        end else begin
          r.out_byte = fifo_mem[head_ptr];
          head_ptr = head_ptr + 1'b1;
          fill--;
        end
      end
      MODE_PEEK: begin
        if (it.offset >= fill) r.status = ST_MISS;
        else r.out_byte = fifo_mem[AW'(head_ptr + it.offset)];
      end
      MODE_DISCARD: begin
        cnt = (it.count > fill) ? fill : it.count;
        head_ptr = AW'(head_ptr + cnt);
        fill -= cnt;
        r.result_value = cnt;
      end
      MODE_SEARCH: begin
        r.status = ST_MISS;
        for (int unsigned i = it.offset; i < fill; i++) begin
          if (fifo_mem[AW'(head_ptr + i)] == it.data_byte) begin
            r.result_value = i;
            r.status = ST_OK;
            break;
          end
        end
      end
      MODE_CHECKSUM: begin
        if (it.offset + it.count > fill) begin
          r.result_value = 1;
          r.status = ST_MISS;
        end else begin
          a = 1;
          b = 0;
          for (int unsigned i = 0; i < it.count; i++) begin
            a = (a + fifo_mem[AW'(head_ptr + it.offset + i)]) % ADLER_MOD;
            b = (b + a) % ADLER_MOD;
          end
          r.result_value = {b[15:0], a[15:0]};
        end
      end
      default: r.status = ST_MISS;
    endcase
    if (fill == 0) begin
      head_ptr = '0;
      tail_ptr = '0;
    end
    r.fill_level = fill[10:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      head_ptr = '0;
      tail_ptr = '0;
      fill = 0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_item) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(fifo_predict(in_item));
    end
    pending_count <= expected_q.size();
  end
endmodule

FILE: test/testbench.sv
// Testbench top: drives command beats into the ring buffer and gives the verdict.
module testbench;
  import brbsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count, pending_count, result_count;
  int        cycle_count;
  int        model_fill;

  byte_ring_buffer_search_checksum_top i_dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item
  );

  brbsc_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .fail_count, .pending_count, .result_count
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 8000000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Rough fill tracking so that offsets land mostly inside the held bytes.
  task automatic send_beat(logic [2:0] m, logic [7:0] d, logic [10:0] o,
                           logic [10:0] c, bit may_idle);
    while (may_idle && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{mode: m, data_byte: d, offset: o, count: c};
    @(posedge clk);
    while (busy) @(posedge clk);
    case (m)
      MODE_PUSH: if (model_fill < DEPTH) model_fill++;
      MODE_POP: if (model_fill > 0) model_fill--;
      MODE_DISCARD: model_fill -= (c > model_fill) ? model_fill : c;
      default: ;
    endcase
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
  endtask

  task automatic random_beat(bit may_idle);
    int unsigned sel, lim;
    logic [10:0] o, c;
    sel = $urandom_range(99);
    lim = (model_fill > 0) ? model_fill : 1;
    o = (sel % 7 == 0) ? 11'($urandom) : 11'($urandom_range(lim - 1));
    c = (sel % 5 == 0) ? 11'($urandom) : 11'($urandom_range(12));
    if (sel < 40) send_beat(MODE_PUSH, 8'($urandom), o, c, may_idle);
    else if (sel < 52) send_beat(MODE_POP, 8'($urandom), o, c, may_idle);
    else if (sel < 64) send_beat(MODE_PEEK, 8'($urandom), o, c, may_idle);
    else if (sel < 70) send_beat(MODE_DISCARD, 8'($urandom), o, c, may_idle);
    else if (sel < 83) send_beat(MODE_SEARCH, 8'($urandom_range(3)), o, c, may_idle);
    else if (sel < 97) send_beat(MODE_CHECKSUM, 8'($urandom), o, c, may_idle);
    else send_beat(3'($urandom_range(6, 7)), 8'($urandom), o, c, may_idle);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    model_fill = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-buffer corners, fill to full, overflow, all modes
    send_beat(MODE_POP, 8'h00, 11'd0, 11'd0, 0);
    send_beat(MODE_PEEK, 8'h00, 11'd0, 11'd0, 0);
    send_beat(MODE_SEARCH, 8'h00, 11'd0, 11'd0, 0);
    send_beat(MODE_CHECKSUM, 8'h00, 11'd0, 11'd0, 0);
    send_beat(MODE_CHECKSUM, 8'h00, 11'd0, 11'd1, 0);
    send_beat(MODE_DISCARD, 8'h00, 11'd0, 11'h7ff, 0);
    send_beat(3'd6, 8'hff, 11'h7ff, 11'h7ff, 0);
    send_beat(3'd7, 8'h00, 11'd0, 11'd0, 0);
    send_beat(MODE_PUSH, 8'hff, 11'h7ff, 11'h7ff, 0);
    send_beat(MODE_SEARCH, 8'hff, 11'd0, 11'd0, 0);
    send_beat(MODE_POP, 8'h00, 11'd0, 11'd0, 0);
    for (int i = 0; i < DEPTH; i++) send_beat(MODE_PUSH, 8'(i * 7 + 3), 11'd0, 11'd0, 1);
    send_beat(MODE_PUSH, 8'h5a, 11'd0, 11'd0, 0);
    send_beat(MODE_PEEK, 8'h00, 11'd1023, 11'd0, 0);
    send_beat(MODE_PEEK, 8'h00, 11'd1024, 11'd0, 0);
    send_beat(MODE_CHECKSUM, 8'h00, 11'd0, 11'd1024, 0);
    send_beat(MODE_CHECKSUM, 8'h00, 11'd1, 11'd1024, 0);
    send_beat(MODE_SEARCH, 8'h00, 11'd1000, 11'd0, 0);
    send_beat(MODE_DISCARD, 8'h00, 11'd0, 11'd1000, 0);
    send_beat(MODE_PUSH, 8'h11, 11'd0, 11'd0, 0);
    send_beat(MODE_CHECKSUM, 8'h00, 11'd10, 11'd15, 0);
    send_beat(MODE_DISCARD, 8'h00, 11'd0, 11'h7ff, 0);
    drain();

    // random, with a back-to-back stretch in the middle and a full drain pause
    for (int n = 0; n < 160; n++) begin
      random_beat(!(n >= 50 && n < 110));
      if (n == 120) drain();
    end
    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d results over push, pop, peek, discard, search, checksum",
             result_count);
    $display("including full, empty, out of range and unknown mode cases");
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/brbsc_pkg.sv
rtl/core/brbsc_mem.sv
rtl/core/brbsc_adler.sv
rtl/core/byte_ring_buffer_search_checksum_top.sv
test/brbsc_checker.sv
test/testbench.sv
